// File: design/ula_pkg.sv
// Shared types and constants for the UART line assembler.
// No dependencies.
package ula_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// register word index
	localparam logic [APB_ADDR_W-3:0] REG_DELIVER_ENABLE = '0;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ECHO = 3'b010,
		ST_SEND = 3'b100
	} ula_state_t;

	typedef struct packed {
		logic busy;
		logic sending;
		logic fill_zero;
	} ula_status_t;

endpackage

// File: design/ula_line_mem.sv
// Line store: single-port-write, single-port-read synchronous RAM,
// with registered read data. No package dependencies.
module ula_line_mem #(
	parameter int LINE_DEPTH = 32,
	parameter int ADDR_W = $clog2(LINE_DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [LINE_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/ula_ctrl.sv
// Sequencer of the line assembler: fill count, echo and line read-out
// with output register. Depends on ula_pkg; drives ula_line_mem.
module ula_ctrl #(
	parameter int LINE_DEPTH = 32,
	parameter int CNT_W = $clog2(LINE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             rx_byte,
	input  logic                   deliver_enable,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   out_kind,
	output logic [7:0]             out_byte,
	output logic                   last_of_run,
	output logic                   wr_en,
	output logic [CNT_W-1:0]       wr_addr,
	output logic [7:0]             wr_data,
	output logic                   rd_en,
	output logic [CNT_W-1:0]       rd_addr,
	input  logic [7:0]             rd_data,
	output ula_pkg::ula_status_t   status
);

	import ula_pkg::*;

	ula_state_t       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       byte_q;
	logic             dlv_q;
	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic accept;
	logic is_term;
	logic slot_free;
	logic load;
	logic run_last;
	logic [CNT_W-1:0] fill_next;

	assign is_term   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign load      = slot_free && ((state_q == ST_ECHO) || (state_q == ST_SEND));
	assign run_last  = (idx_q == (len_q - 1'b1));
	assign fill_next = (fill_q == CNT_W'(LINE_DEPTH - 2)) ? '0 : fill_q + 1'b1;

	assign wr_en   = accept && !is_term;
	assign wr_addr = fill_q;
	assign wr_data = rx_byte;

	// prefetch entry 0 during echo, then one entry ahead per char sent
	assign rd_en   = (state_q == ST_ECHO) ||
	                 ((state_q == ST_SEND) && slot_free && !run_last);
	assign rd_addr = (state_q == ST_ECHO) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			dlv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_ECHO;
						if (is_term) begin
							dlv_q  <= (fill_q != '0) && deliver_enable;
							fill_q <= '0;
						end else begin
							dlv_q  <= 1'b0;
							fill_q <= fill_next;
						end
					end
				end
				ST_ECHO: begin
					if (slot_free) begin
						state_q <= dlv_q ? ST_SEND : ST_IDLE;
					end
				end
				ST_SEND: begin
					if (slot_free) begin
						if (run_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx_byte;
			len_q  <= fill_q;
		end
		if (load) begin
			if (state_q == ST_SEND) begin
				out_kind_q <= KIND_LINE;
				out_byte_q <= rd_data;
				out_last_q <= run_last;
			end else begin
				out_kind_q <= KIND_ECHO;
				out_byte_q <= byte_q;
				out_last_q <= !dlv_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	assign status.busy      = (state_q != ST_IDLE);
	assign status.sending   = (state_q == ST_SEND);
	assign status.fill_zero = (fill_q == '0);

endmodule

// File: design/uart_line_assembler.sv
// Top level of the UART line assembler: APB register, sequencer, line store.
// Depends on ula_pkg, ula_ctrl and ula_line_mem.
//
// Each received byte is echoed; CR or LF closes the line and, with
// deliver_enable set, the stored characters follow one per cycle while
// the output is not stalled, read out of the line store through its
// single read port one entry a cycle. A byte that is appended or a
// terminator that delivers nothing passes through the echo state, which
// loads its echo into the output register, and the sequencer then returns
// to idle for the next byte. The output register lets a new byte be
// accepted while the last result is still waiting. No clearing pass after
// reset: only entries of the current line are ever delivered.
module uart_line_assembler #(
	parameter int LINE_DEPTH = ula_pkg::LINE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            out_kind,
	output logic [7:0]                      out_byte,
	output logic                            last_of_run,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ula_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	import ula_pkg::*;

	localparam int CNT_W = $clog2(LINE_DEPTH);

	logic             deliver_enable_q;
	logic             reg_hit;
	logic             wr_en;
	logic [CNT_W-1:0] wr_addr;
	logic [7:0]       wr_data;
	logic             rd_en;
	logic [CNT_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	ula_status_t      status;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_DELIVER_ENABLE);
	assign prdata  = reg_hit ? {31'b0, deliver_enable_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			deliver_enable_q <= pwdata[0];
		end
	end

	ula_ctrl #(
		.LINE_DEPTH (LINE_DEPTH),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.deliver_enable (deliver_enable_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.status         (status)
	);

	ula_line_mem #(
		.LINE_DEPTH (LINE_DEPTH),
		.ADDR_W     (CNT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> status.busy)
		else $error("sequencer not busy after transaction accepted");

	a_fill_clear_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		status.sending |-> status.fill_zero)
		else $error("fill count non-zero during line read-out");

	a_busy_needs_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status.busy) |-> $past(in_valid))
		else $error("sequencer started without an input transaction");

endmodule
